// File: hw/rtl/tpf_pkg.sv
// Shared types and constants for the thermistor-to-Fahrenheit converter.
package tpf_pkg;

    localparam int unsigned LnFracBits = 24;
    localparam int unsigned LnFracBitsMin = 16;
    localparam int unsigned LnFracBitsMax = 32;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;

    localparam int unsigned QuoBits = 35;
    localparam int unsigned DivStages = QuoBits;
    localparam int unsigned LogIters = 32;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ZERO = 2'd1,
        ST_NONPOS = 2'd2,
        ST_SAT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_DIV_RES = 3'd0,
        REG_SER_RES = 3'd1,
        REG_REF_PCM = 3'd2,
        REG_COEF_A = 3'd3,
        REG_COEF_B = 3'd4,
        REG_COEF_C = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] div_res;
        logic [19:0] ser_res;
        logic [14:0] ref_pcm;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } t_cfg;

    typedef struct packed {
        logic signed [9:0] temp;
        t_status status;
    } t_result;

endpackage

// File: hw/rtl/thermistor_pcm_to_fahrenheit.sv
// Top level: config registers, stage chain and output register.
// Converts one 15-bit peak reading per cycle into Fahrenheit with status. A reading
// passes the resistance divide (product, 35 quotient steps, subtract), the logarithm
// (normalise, 32 squaring steps, ln2 scaling), the polynomial and temperature divide,
// and one output register.
// A new reading may enter every cycle. A stall on the output freezes the whole
// pipeline, so s_axis_tready follows m_axis_tready combinationally while a result waits.
module thermistor_pcm_to_fahrenheit (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] peak_amplitude
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] temp_fahrenheit, [11:10] status
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tpf_pkg::*;

    t_cfg r_cfg;
    logic w_en;
    logic w_v1, w_d1, w_v2, w_d2, w_v3;
    logic [35:0] w_ohms;
    t_status w_s1, w_s2;
    logic [LnFracBits+5:0] w_lnq;
    t_result w_res;
    logic r_ov;
    t_result r_obuf;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_res <= 20'd10000;
            r_cfg.ser_res <= '0;
            r_cfg.ref_pcm <= 15'd32767;
            r_cfg.coef_a <= 32'sd1230000000;
            r_cfg.coef_b <= 32'sd250000000;
            r_cfg.coef_c <= 32'sd100000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIV_RES: r_cfg.div_res <= i_cfg_data[19:0];
                REG_SER_RES: r_cfg.ser_res <= i_cfg_data[19:0];
                REG_REF_PCM: r_cfg.ref_pcm <= i_cfg_data[14:0];
                REG_COEF_A: r_cfg.coef_a <= i_cfg_data;
                REG_COEF_B: r_cfg.coef_b <= i_cfg_data;
                REG_COEF_C: r_cfg.coef_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being drained
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    tpf_ohms u_ohms (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_pcm(s_axis_tdata[14:0]), .i_cfg(r_cfg),
        .o_valid(w_v1), .o_done(w_d1), .o_ohms(w_ohms), .o_status(w_s1)
    );
    tpf_ln u_ln (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v1), .i_ohms(w_ohms),
        .i_done(w_d1), .i_status(w_s1),
        .o_valid(w_v2), .o_done(w_d2), .o_status(w_s2), .o_lnq(w_lnq)
    );
    tpf_temp u_temp (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v2), .i_done(w_d2),
        .i_status(w_s2), .i_lnq(w_lnq), .i_cfg(r_cfg),
        .o_valid(w_v3), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_v3;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_obuf <= w_res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {4'b0, r_obuf.status, r_obuf.temp};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result moved under stall");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11:10] == ST_ZERO |-> m_axis_tdata[9:0] == '0)
        else $error("zero reading with nonzero temperature");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

// File: hw/rtl/tpf_ohms.sv
// Resistance stage: pipelined restoring divide of div_res*ref_pcm by the reading, minus div_res+ser_res.
module tpf_ohms (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic [14:0] i_pcm,
    input  tpf_pkg::t_cfg i_cfg,
    output logic o_valid,
    output logic o_done,
    output logic [35:0] o_ohms,
    output tpf_pkg::t_status o_status
);
    import tpf_pkg::*;

    // stage 0: product; stages 1..35: one quotient bit each; last: subtract
    logic [DivStages:0] r_v;
    logic [QuoBits-1:0] r_num [DivStages+1];
    logic [15:0] r_rem [DivStages+1];
    logic [14:0] r_den [DivStages+1];
    logic [20:0] r_sum [DivStages+1];
    logic r_zero [DivStages+1];
    logic [15:0] n_rem [DivStages];
    logic [QuoBits-1:0] n_num [DivStages];
    logic [36:0] r_res;
    logic r_oz;
    logic r_ov;

    always_comb begin
        for (int s = 0; s < DivStages; s++) begin
            logic [15:0] t;
            t = {r_rem[s][14:0], r_num[s][QuoBits-1]};
            n_num[s] = {r_num[s][QuoBits-2:0], 1'b0};
            if (t >= {1'b0, r_den[s]}) begin
                n_rem[s] = t - {1'b0, r_den[s]};
                n_num[s][0] = 1'b1;
            end else begin
                n_rem[s] = t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v <= {r_v[DivStages-1:0], i_valid};
            r_ov <= r_v[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= QuoBits'(i_cfg.div_res * i_cfg.ref_pcm);
            r_rem[0] <= '0;
            r_den[0] <= i_pcm;
            r_sum[0] <= {1'b0, i_cfg.div_res} + {1'b0, i_cfg.ser_res};
            r_zero[0] <= (i_pcm == '0);
            for (int s = 0; s < DivStages; s++) begin
                r_num[s+1] <= n_num[s];
                r_rem[s+1] <= n_rem[s];
                r_den[s+1] <= r_den[s];
                r_sum[s+1] <= r_sum[s];
                r_zero[s+1] <= r_zero[s];
            end
            r_res <= {2'b0, r_num[DivStages]} - {16'b0, r_sum[DivStages]};
            r_oz <= r_zero[DivStages];
        end
    end

    assign o_valid = r_ov;
    assign o_ohms = r_res[35:0];
    assign o_done = r_oz || r_res[36] || (r_res == '0);
    assign o_status = r_oz ? ST_ZERO : ((r_res[36] || r_res == '0) ? ST_NONPOS : ST_OK);
endmodule

// File: hw/rtl/tpf_ln.sv
// Natural log stage: normalise, 32 pipelined squaring steps, scale by ln2.
module tpf_ln (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic [35:0] i_ohms,
    input  logic i_done,
    input  tpf_pkg::t_status i_status,
    output logic o_valid,
    output logic o_done,
    output tpf_pkg::t_status o_status,
    output logic [tpf_pkg::LnFracBits+5:0] o_lnq
);
    import tpf_pkg::*;

    localparam int unsigned Ns = LogIters + 3;
    logic [Ns-1:0] r_v;
    logic [32:0] r_m [LogIters+1];
    logic [31:0] r_frac [LogIters+1];
    logic [5:0] r_k [LogIters+1];
    logic r_dn [Ns];
    t_status r_st [Ns];
    logic [63:0] r_fl;
    logic [37:0] r_kl;
    logic [LnFracBits+5:0] r_out;
    logic [5:0] n_k;
    logic [32:0] n_m;

    always_comb begin
        n_k = '0;
        for (int b = 0; b < 36; b++)
            if (i_ohms[b]) n_k = 6'(b);
        if (n_k <= 6'd31) n_m = 33'(i_ohms[31:0]) << (6'd31 - n_k);
        else n_m = 33'(i_ohms >> (n_k - 6'd31));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[Ns-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_m;
            r_frac[0] <= '0;
            r_k[0] <= n_k;
            r_dn[0] <= i_done;
            r_st[0] <= i_status;
            for (int s = 0; s < LogIters; s++) begin
                logic [65:0] sq;
                logic [34:0] mm;
                sq = r_m[s] * r_m[s];
                mm = sq[65:31];
                if (mm >= 35'h100000000) begin
                    r_m[s+1] <= mm[33:1];
                    r_frac[s+1] <= {r_frac[s][30:0], 1'b1};
                end else begin
                    r_m[s+1] <= mm[32:0];
                    r_frac[s+1] <= {r_frac[s][30:0], 1'b0};
                end
                r_k[s+1] <= r_k[s];
            end
            for (int s = 0; s < Ns - 1; s++) begin
                r_dn[s+1] <= r_dn[s];
                r_st[s+1] <= r_st[s];
            end
            r_fl <= r_frac[LogIters] * Ln2Q32;
            r_kl <= r_k[LogIters] * Ln2Q32;
            r_out <= (LnFracBits+6)'(({6'b0, r_kl} + {12'b0, r_fl[63:32]})
                                     >> (32 - LnFracBits));
        end
    end

    assign o_valid = r_v[Ns-1];
    assign o_done = r_dn[Ns-1];
    assign o_status = r_st[Ns-1];
    assign o_lnq = r_out;
endmodule

// File: hw/rtl/tpf_temp.sv
// Polynomial and Fahrenheit stage: powers, coefficient terms, pipelined signed divide.
module tpf_temp (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic i_done,
    input  tpf_pkg::t_status i_status,
    input  logic [tpf_pkg::LnFracBits+5:0] i_lnq,
    input  tpf_pkg::t_cfg i_cfg,
    output logic o_valid,
    output tpf_pkg::t_result o_res
);
    import tpf_pkg::*;

    localparam int unsigned Lw = LnFracBits + 6;
    localparam int unsigned Qb = 11; // quotient bits needed to see saturation
    localparam int unsigned Ns = 7 + Qb;
    logic [Ns-1:0] r_v;
    logic r_dn [Ns];
    t_status r_st [Ns];
    logic [Lw-1:0] r_l1, r_l2;
    logic [Lw+5:0] r_sq;
    logic [Lw+11:0] r_cube;
    // coefficient products, the C one split in two parts
    logic [Lw+31:0] r_pb;
    logic [50:0] r_pcl;
    logic [Lw+24:0] r_pch;
    logic signed [63:0] r_tb, r_tc, r_d;
    logic signed [63:0] r_num;
    logic signed [63:0] r_den;
    // sign-magnitude long divide
    logic [63:0] r_qa [Qb+1];
    logic [70:0] r_ra [Qb+1];
    logic [63:0] r_da [Qb+1];
    logic [Qb-1:0] r_q [Qb+1];
    logic r_ng [Qb+1];
    logic r_big [Qb+1];
    logic r_dz [Qb+1];
    t_result r_out;
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v <= {r_v[Ns-2:0], i_valid};
            r_ov <= r_v[Ns-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [2*Lw-1:0] p1;
            logic [2*Lw+5:0] p2;
            logic [63:0] mb, mc;
            logic [95:0] pc;
            logic signed [63:0] d;
            logic [63:0] an, ad;
            r_dn[0] <= i_done;
            r_st[0] <= i_status;
            for (int s = 0; s < Ns - 1; s++) begin
                r_dn[s+1] <= r_dn[s];
                r_st[s+1] <= r_st[s];
            end
            // s0 -> s1: square
            p1 = i_lnq * i_lnq;
            r_sq <= (Lw+6)'(p1 >> LnFracBits);
            r_l1 <= i_lnq;
            // s1 -> s2: cube
            p2 = r_sq * r_l1;
            r_cube <= (Lw+12)'(p2 >> LnFracBits);
            r_l2 <= r_l1;
            // s2 -> s3: coefficient magnitude products
            mb = i_cfg.coef_b[31] ? 64'(-{{32{i_cfg.coef_b[31]}}, i_cfg.coef_b})
                                  : 64'(i_cfg.coef_b);
            mc = i_cfg.coef_c[31] ? 64'(-{{32{i_cfg.coef_c[31]}}, i_cfg.coef_c})
                                  : 64'(i_cfg.coef_c);
            r_pb <= mb[31:0] * r_l2;
            r_pcl <= mc[31:0] * r_cube[18:0];
            r_pch <= mc[31:0] * r_cube[Lw+11:19];
            // s3 -> s4: signed coefficient terms
            pc = 96'({r_pch, 19'b0}) + 96'(r_pcl);
            r_tb <= i_cfg.coef_b[31] ? -$signed(64'(r_pb >> LnFracBits))
                                     : $signed(64'(r_pb >> LnFracBits));
            r_tc <= i_cfg.coef_c[31] ? -$signed(64'(pc >> LnFracBits))
                                     : $signed(64'(pc >> LnFracBits));
            // s4 -> s5: D
            r_d <= 64'(i_cfg.coef_a) + r_tb + r_tc;
            // s5 -> s6: numerator and denominator
            r_num <= $signed(64'(180) <<< 40) - 64'sd45967 * r_d;
            r_den <= 64'sd100 * r_d;
            // s6 -> divider entry
            d = r_den;
            an = r_num[63] ? 64'(-r_num) : 64'(r_num);
            ad = d[63] ? 64'(-d) : 64'(d);
            r_qa[0] <= an;
            r_da[0] <= ad;
            r_ra[0] <= 71'(an >> Qb);
            r_q[0] <= '0;
            r_ng[0] <= r_num[63] ^ d[63];
            r_dz[0] <= (d == 0);
            // quotient >= 2^Qb saturates regardless of sign
            r_big[0] <= (ad != 0) && ((an >> Qb) >= ad);
            for (int s = 0; s < Qb; s++) begin
                logic [70:0] t;
                t = {r_ra[s][69:0], r_qa[s][Qb-1-s]};
                if (t >= 71'(r_da[s]) && !r_big[s]) begin
                    r_ra[s+1] <= t - 71'(r_da[s]);
                    r_q[s+1] <= {r_q[s][Qb-2:0], 1'b1};
                end else begin
                    r_ra[s+1] <= t;
                    r_q[s+1] <= {r_q[s][Qb-2:0], 1'b0};
                end
                r_qa[s+1] <= r_qa[s];
                r_da[s+1] <= r_da[s];
                r_ng[s+1] <= r_ng[s];
                r_big[s+1] <= r_big[s];
                r_dz[s+1] <= r_dz[s];
            end
            // final: the low Qb bits of the dividend feed the divide; higher bits
            // are handled by the r_big screen, so the remainder starts from an>>Qb
            if (r_dn[Ns-1]) begin
                r_out.temp <= '0;
                r_out.status <= r_st[Ns-1];
            end else if (r_dz[Qb]) begin
                r_out.temp <= 10'sd511;
                r_out.status <= ST_SAT;
            end else if (r_big[Qb] || (!r_ng[Qb] && r_q[Qb] > 11'd511)) begin
                r_out.temp <= r_ng[Qb] ? -10'sd512 : 10'sd511;
                r_out.status <= ST_SAT;
            end else if (r_ng[Qb] && r_q[Qb] > 11'd512) begin
                r_out.temp <= -10'sd512;
                r_out.status <= ST_SAT;
            end else begin
                r_out.temp <= r_ng[Qb] ? 10'(-r_q[Qb]) : r_q[Qb][9:0];
                r_out.status <= ST_OK;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_res = r_out;
endmodule
